// File: rtl/cosine_similarity_engine_macros.svh
// Assertion helpers for the cosine similarity engine.
`ifndef COSINE_SIMILARITY_ENGINE_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define CSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cse assertion failed");
`define CSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cse assertion failed");
`else
`define CSE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CSE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/cse_pkg.sv
`default_nettype none

package cse_pkg;

    localparam int ELEM_W    = 16;
    localparam int SIM_W     = 16;
    localparam int STAT_W    = 2;
    localparam int FRAC_W    = 15;
    localparam int Q_W       = FRAC_W + 1;
    localparam int BIT_IDX_W = $clog2(Q_W);
    // two operand pairs, four partial products each
    localparam int PP_STEPS  = 8;
    localparam int PP_SEL_W  = $clog2(PP_STEPS);

    localparam int DEF_MAX_LEN     = 4096;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO_NORM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic signed [ELEM_W-1:0] x_elem;
        logic signed [ELEM_W-1:0] y_elem;
        logic                     last_elem;
    } in_word_t;

    typedef struct packed {
        logic signed [SIM_W-1:0] similarity;
        logic [STAT_W-1:0]       status;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_CHECK,
        ST_MUL,
        ST_ROOT_ADD,
        ST_ROOT_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 acc_en;
        logic                 acc_clr;
        logic                 check;
        logic                 mul_issue;
        logic [PP_SEL_W-1:0]  mul_sel;
        logic                 root_add;
        logic                 root_cmp;
        logic [BIT_IDX_W-1:0] bit_idx;
        logic                 load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic err;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/cse_datapath.sv
`default_nettype none
`include "cosine_similarity_engine_macros.svh"

module cse_datapath
    import cse_pkg::*;
#(
    parameter int MAX_LEN     = DEF_MAX_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dp_cmd_t   cmd,
    input  wire in_word_t  in_word,
    output dp_stat_t       stat,
    output out_word_t      out_word
);

    localparam int LEN_W   = $clog2(MAX_LEN);
    localparam int NORM_W  = 2 * SAMPLE_BITS - 1 + LEN_W;
    localparam int DOT_W   = NORM_W + 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int HALF_W  = (DOT_W + 1) / 2;
    localparam int PROD_W  = 4 * HALF_W;
    localparam int QP_W    = PROD_W + Q_W;
    localparam int CMP_W   = PROD_W + 2 * Q_W + 1;
    localparam int SH_W    = BIT_IDX_W + 1;

    // ---------------- accumulation ----------------
    logic signed [SAMPLE_BITS-1:0]   x_s, y_s;
    logic signed [2*SAMPLE_BITS-1:0] xy, xx, yy;

    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [NORM_W-1:0]       nx_reg, nx_next;
    logic [NORM_W-1:0]       ny_reg, ny_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;

    generate
        if (SAMPLE_BITS <= ELEM_W) begin : g_narrow
            assign x_s = in_word.x_elem[SAMPLE_BITS-1:0];
            assign y_s = in_word.y_elem[SAMPLE_BITS-1:0];
        end else begin : g_wide
            assign x_s = {{(SAMPLE_BITS-ELEM_W){1'b0}}, in_word.x_elem};
            assign y_s = {{(SAMPLE_BITS-ELEM_W){1'b0}}, in_word.y_elem};
        end
    endgenerate

    assign xy = x_s * y_s;
    assign xx = x_s * x_s;
    assign yy = y_s * y_s;

    // squares are never negative, so the top product bit is always clear
    assign dot_next = dot_reg + DOT_W'(xy);
    assign nx_next  = nx_reg + NORM_W'(xx[2*SAMPLE_BITS-2:0]);
    assign ny_next  = ny_reg + NORM_W'(yy[2*SAMPLE_BITS-2:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.acc_clr) begin
            dot_reg <= '0;
            nx_reg  <= '0;
            ny_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.acc_en) begin
            if (cnt_reg < CNT_W'(MAX_LEN)) begin
                dot_reg <= dot_next;
                nx_reg  <= nx_next;
                ny_reg  <= ny_next;
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    assign stat.err = ovf_reg || (nx_reg == '0) || (ny_reg == '0);

    // ---------------- shared multiplier ----------------
    logic [DOT_W-1:0]    mag_reg;
    logic                neg_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [DOT_W-1:0]    op_a, op_b;
    logic [2*HALF_W-1:0] a_ext, b_ext;
    logic [HALF_W-1:0]   a_half, b_half;
    logic [2*HALF_W-1:0] pp_reg;
    logic [PP_SEL_W-1:0] pp_sel_reg;
    logic                pp_valid_reg;
    logic [PROD_W-1:0]   pp_shift;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   d2_reg;

    // sel[2]: norm product or dot squared; sel[1]/sel[0]: upper half of a/b
    assign op_a   = cmd.mul_sel[2] ? mag_reg : DOT_W'(nx_reg);
    assign op_b   = cmd.mul_sel[2] ? mag_reg : DOT_W'(ny_reg);
    assign a_ext  = (2*HALF_W)'(op_a);
    assign b_ext  = (2*HALF_W)'(op_b);
    assign a_half = cmd.mul_sel[1] ? a_ext[2*HALF_W-1:HALF_W] : a_ext[HALF_W-1:0];
    assign b_half = cmd.mul_sel[0] ? b_ext[2*HALF_W-1:HALF_W] : b_ext[HALF_W-1:0];

    always_comb begin
        pp_shift = PROD_W'(pp_reg);
        if (pp_sel_reg[1]) begin
            pp_shift = pp_shift << HALF_W;
        end
        if (pp_sel_reg[0]) begin
            pp_shift = pp_shift << HALF_W;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_valid_reg <= 1'b0;
        end else begin
            pp_valid_reg <= cmd.mul_issue;
        end
    end

    // ---------------- bitwise root search ----------------
    // q is built MSB first; q^2 * P is kept incrementally in s_reg, q * P in qp_reg
    logic [CMP_W-1:0] num;
    logic [CMP_W-1:0] s_reg;
    logic [CMP_W-1:0] t_reg;
    logic [QP_W-1:0]  qp_reg;
    logic [Q_W-1:0]   q_reg;
    logic [SH_W-1:0]  sh_a, sh_b;
    logic             fits;

    assign num  = CMP_W'({d2_reg, {(2*FRAC_W){1'b0}}});
    assign sh_a = SH_W'(cmd.bit_idx) + SH_W'(1);
    assign sh_b = {cmd.bit_idx, 1'b0};
    // once full scale is taken no lower bit may be added
    assign fits = (t_reg <= num) && !q_reg[Q_W-1];

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            mag_reg    <= dot_reg[DOT_W-1] ? (~dot_reg + 1'b1) : dot_reg;
            neg_reg    <= dot_reg[DOT_W-1];
            status_reg <= ovf_reg ? STAT_OVERFLOW :
                          ((nx_reg == '0) || (ny_reg == '0)) ? STAT_ZERO_NORM : STAT_OK;
            prod_reg   <= '0;
            d2_reg     <= '0;
            s_reg      <= '0;
            qp_reg     <= '0;
        end else begin
            if (pp_valid_reg) begin
                if (pp_sel_reg[2]) begin
                    d2_reg <= d2_reg + pp_shift;
                end else begin
                    prod_reg <= prod_reg + pp_shift;
                end
            end
            if (cmd.root_cmp && fits) begin
                s_reg  <= t_reg;
                qp_reg <= qp_reg + (QP_W'(prod_reg) << cmd.bit_idx);
            end
        end
        if (cmd.mul_issue) begin
            pp_reg     <= a_half * b_half;
            pp_sel_reg <= cmd.mul_sel;
        end
        if (cmd.root_add) begin
            t_reg <= s_reg + (CMP_W'(qp_reg) << sh_a) + (CMP_W'(prod_reg) << sh_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.check) begin
            q_reg <= '0;
        end else if (cmd.root_cmp && fits) begin
            q_reg <= q_reg | (Q_W'(1) << cmd.bit_idx);
        end
    end

    // ---------------- result word ----------------
    logic signed [SIM_W-1:0] sim;
    out_word_t               out_reg;

    always_comb begin
        if (status_reg != STAT_OK) begin
            sim = '0;
        end else if (neg_reg) begin
            sim = SIM_W'(~q_reg + 1'b1);
        end else if (q_reg[Q_W-1]) begin
            sim = {1'b0, {(SIM_W-1){1'b1}}};
        end else begin
            sim = SIM_W'(q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.similarity <= sim;
            out_reg.status     <= status_reg;
        end
    end

    assign out_word = out_reg;

    `CSE_ASSERT_IMP(a_q_range, aclk, aresetn, q_reg[Q_W-1], q_reg[Q_W-2:0] == '0)

endmodule

`default_nettype wire

// File: rtl/cse_ctrl.sv
`default_nettype none
`include "cosine_similarity_engine_macros.svh"

module cse_ctrl
    import cse_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire logic     last_elem,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam int MCNT_W = PP_SEL_W + 1;

    state_t                state_reg, state_next;
    logic [MCNT_W-1:0]     mul_cnt_reg, mul_cnt_next;
    logic [BIT_IDX_W-1:0]  bit_reg, bit_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        mul_cnt_next = mul_cnt_reg;
        bit_next     = bit_reg;
        unique case (state_reg)
            ST_ACCUM: begin
                if (s_valid && last_elem) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                mul_cnt_next = '0;
                state_next   = stat.err ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                // the last partial product is accumulated in the cycle after it is issued
                if (mul_cnt_reg == MCNT_W'(PP_STEPS)) begin
                    state_next = ST_ROOT_ADD;
                    bit_next   = BIT_IDX_W'(Q_W - 1);
                end else begin
                    mul_cnt_next = mul_cnt_reg + 1'b1;
                end
            end
            ST_ROOT_ADD: begin
                state_next = ST_ROOT_CMP;
            end
            ST_ROOT_CMP: begin
                if (bit_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_ROOT_ADD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.mul_sel   = mul_cnt_reg[PP_SEL_W-1:0];
        cmd.bit_idx   = bit_reg;
        unique case (state_reg)
            ST_ACCUM: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
            end
            ST_MUL: begin
                cmd.mul_issue = (mul_cnt_reg < MCNT_W'(PP_STEPS));
            end
            ST_ROOT_ADD: begin
                cmd.root_add = 1'b1;
            end
            ST_ROOT_CMP: begin
                cmd.root_cmp = 1'b1;
            end
            ST_DONE: begin
                cmd.load_out = out_free;
                cmd.acc_clr  = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            mul_cnt_reg <= '0;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mul_cnt_reg <= mul_cnt_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `CSE_ASSERT_NXT(a_last_stalls, aclk, aresetn, s_valid && s_ready && last_elem, !s_ready)
    `CSE_ASSERT_IMP(a_mul_bound, aclk, aresetn, 1'b1, mul_cnt_reg <= MCNT_W'(PP_STEPS))
    `CSE_ASSERT_NXT(a_load_shows, aclk, aresetn, cmd.load_out, m_valid)

endmodule

`default_nettype wire

// File: rtl/cosine_similarity_engine.sv
`default_nettype none

// Cosine similarity of two vectors streamed as element pairs, one word per
// cycle, with last_elem on the final pair. Pairs are accumulated at one per
// cycle. After the last pair the block stops taking words for the closing
// computation: a check state, a shared half-width multiplier for
// norm_x*norm_y and dot^2, and the 16-bit restoring root search (an add
// state and a compare state per result bit), then the result is loaded once
// the output register is free. A zero-norm or overflow status skips the
// multiplier and the root search. A loaded result waits in the output
// register while the next vector streams in. Similarity is Q1.15 truncated
// toward zero and saturated; status 1 flags a zero norm, status 2 more than
// MAX_LEN pairs, and both force similarity to 0.
module cosine_similarity_engine
    import cse_pkg::*;
#(
    parameter int MAX_LEN     = DEF_MAX_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cse_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .last_elem (s_data.last_elem),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cse_datapath #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_word  (s_data),
        .stat     (stat),
        .out_word (m_data)
    );

endmodule

`default_nettype wire

// File: sim/cse_checker.sv
`timescale 1ns / 1ps

module cse_checker
    import cse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        fail_count,
    output int        pending,
    output int        score_count,
    output int        zero_norm_count,
    output int        too_long_count
);

    localparam int DOT_W     = 44;
    localparam int NORM_W    = 43;
    localparam int MAX_PAIRS = DEF_MAX_LEN;

    logic signed [DOT_W-1:0] dot_sum;
    logic [NORM_W-1:0]       xx_sum;
    logic [NORM_W-1:0]       yy_sum;
    int unsigned             pairs_taken;
    bit                      too_long;
    out_word_t               scores_due[$];
    int                      fails;
    int                      checked;
    int                      n_zero;
    int                      n_long;

    // Largest q in [0, 32768] with q^2 * nx * ny <= dot^2 * 2^30, signed by dot.
    function automatic logic signed [SIM_W-1:0] cosine_q15(
        input logic signed [DOT_W-1:0] dot,
        input logic [NORM_W-1:0]       nx,
        input logic [NORM_W-1:0]       ny
    );
        logic [DOT_W-1:0] mag;
        logic [127:0]     norm_prod;
        logic [127:0]     dot_sq;
        logic [127:0]     trial;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        int               q;
        mag = dot[DOT_W-1] ? -dot : dot;
        dot_sq = 128'(mag);
        dot_sq = (dot_sq * dot_sq) << 30;
        norm_prod = 128'(nx) * 128'(ny);
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            trial = norm_prod * 128'(mid * mid);
            if (trial <= dot_sq) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        q = int'(lo);
        if (dot[DOT_W-1]) begin
            q = -q;
        end else if (q > 32767) begin
            q = 32767;
        end
        return q[SIM_W-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        out_word_t               want;
        logic signed [ELEM_W-1:0] xs;
        logic signed [ELEM_W-1:0] ys;
        logic signed [31:0]       pxy;
        logic signed [31:0]       pxx;
        logic signed [31:0]       pyy;
        if (!aresetn) begin
            dot_sum = '0;
            xx_sum = '0;
            yy_sum = '0;
            pairs_taken = 0;
            too_long = 1'b0;
            scores_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (scores_due.size() == 0) begin
                    $display("%0t: result word with none expected: similarity %0d status %0d",
                             $time, $signed(m_data.similarity), m_data.status);
                    fails++;
                end else begin
                    want = scores_due.pop_front();
                    checked++;
                    if (m_data.similarity !== want.similarity) begin
                        $display("%0t: similarity mismatch, expected %0d, got %0d", $time,
                                 $signed(want.similarity), $signed(m_data.similarity));
                        fails++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d", $time,
                                 want.status, m_data.status);
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                xs = s_data.x_elem;
                ys = s_data.y_elem;
                pxy = xs * ys;
                pxx = xs * xs;
                pyy = ys * ys;
                // pairs past the length limit are dropped but poison the result
                if (pairs_taken < MAX_PAIRS) begin
                    dot_sum = dot_sum + pxy;
                    xx_sum = xx_sum + pxx;
                    yy_sum = yy_sum + pyy;
                    pairs_taken++;
                end else begin
                    too_long = 1'b1;
                end
                if (s_data.last_elem) begin
                    want.similarity = '0;
                    want.status = STAT_OK;
                    if (too_long) begin
                        want.status = STAT_OVERFLOW;
                        n_long++;
                    end else if (xx_sum == 0 || yy_sum == 0) begin
                        want.status = STAT_ZERO_NORM;
                        n_zero++;
                    end else begin
                        want.similarity = cosine_q15(dot_sum, xx_sum, yy_sum);
                    end
                    scores_due = {scores_due, want};
                    dot_sum = '0;
                    xx_sum = '0;
                    yy_sum = '0;
                    pairs_taken = 0;
                    too_long = 1'b0;
                end
            end
        end
        fail_count <= fails;
        pending <= scores_due.size();
        score_count <= checked;
        zero_norm_count <= n_zero;
        too_long_count <= n_long;
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cse_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 175;  // pairs sent per idle/stall phase

    typedef enum int {
        VEC_FULL,
        VEC_SMALL,
        VEC_ALIGNED,
        VEC_EDGE,
        VEC_HALF_ZERO
    } vec_kind_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    int fail_count;
    int pending;
    int score_count;
    int zero_norm_count;
    int too_long_count;

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent      = 0;
    int quiet     = 0;

    logic signed [ELEM_W-1:0] edge_vals[5] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001,
                                               16'shFFFF};

    cosine_similarity_engine u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    cse_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .score_count     (score_count),
        .zero_norm_count (zero_norm_count),
        .too_long_count  (too_long_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        quiet <= (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) ? 0 : quiet + 1;
    end

    initial begin
        while (quiet < IDLE_LIMIT) @(posedge aclk);
        $display("testbench: FAIL");
        $finish;
    end

    task automatic send_pair(input logic signed [ELEM_W-1:0] x, input logic signed [ELEM_W-1:0] y,
                             input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{x_elem: x, y_elem: y, last_elem: last};
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic send_vector(input int len, input vec_kind_t kind);
        logic signed [ELEM_W-1:0] x;
        logic signed [ELEM_W-1:0] y;
        bit                       zero_x;
        zero_x = 1'($urandom_range(1));
        for (int i = 0; i < len; i++) begin
            x = ELEM_W'($urandom);
            y = ELEM_W'($urandom);
            case (kind)
                VEC_SMALL: begin
                    x = ELEM_W'($urandom_range(15)) - ELEM_W'(8);
                    y = ELEM_W'($urandom_range(15)) - ELEM_W'(8);
                end
                VEC_ALIGNED: begin
                    // near-parallel or anti-parallel vectors land close to full scale
                    y = $urandom_range(1) ? x : -x;
                    if ($urandom_range(3) == 0) y = y >>> 3;
                    y = y + ELEM_W'($urandom_range(7)) - ELEM_W'(4);
                end
                VEC_EDGE: begin
                    x = edge_vals[$urandom_range(4)];
                    y = edge_vals[$urandom_range(4)];
                end
                VEC_HALF_ZERO: begin
                    if (zero_x) x = '0;
                    else y = '0;
                end
                default: ;
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    // stop offering words until every pending result is out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int idle, input int stall);
        int        first;
        int        len;
        int        r;
        vec_kind_t kind;
        drain();
        idle_pct = idle;
        stall_pct <= stall;
        first = sent;
        while (sent - first < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            len = (r < 80) ? $urandom_range(1, 12) :
                  (r < 97) ? $urandom_range(13, 64) : $urandom_range(65, 120);
            r = $urandom_range(99);
            kind = (r < 40) ? VEC_FULL :
                   (r < 60) ? VEC_SMALL :
                   (r < 80) ? VEC_ALIGNED :
                   (r < 93) ? VEC_EDGE : VEC_HALF_ZERO;
            send_vector(len, kind);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-pair vectors at full scale, both signs
        send_pair(16'sd1, 16'sd1, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        // zero norms on either side and both
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(16'sd7, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        // orthogonal, then a plain 3-4-5 case
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, 16'sd3, 1'b1);
        send_pair(16'sd100, -16'sd200, 1'b0);
        send_pair(16'sd300, 16'sd50, 1'b0);
        send_pair(-16'sd7, 16'sd9, 1'b1);
        send_pair(16'sh7FFF, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7FFF, 1'b0);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);

        run_phase(0, 0);
        run_phase(57, 0);
        run_phase(0, 57);
        run_phase(30, 30);

        // receiver holds off while short vectors keep coming, so the block backs up
        drain();
        idle_pct = 0;
        stall_pct <= 0;
        hold_asks <= hold_asks + 1;
        repeat (40) send_vector($urandom_range(1, 3), VEC_FULL);

        drain();
        repeat (60) @(posedge aclk);

        $display("testbench: %0d words sent, %0d results checked (%0d zero-norm, %0d over-length)",
                 sent, score_count, zero_norm_count, too_long_count);
        $display("testbench: covered four idle/stall mixes, corner vectors and a long output hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
